>>> design/tie_averaged_rank_assigner_top_macros.svh
// Assertion macros used by the checker file of the rank assigner.
`ifndef TIE_AVERAGED_RANK_ASSIGNER_TOP_MACROS_SVH
`define TIE_AVERAGED_RANK_ASSIGNER_TOP_MACROS_SVH

// Implication checked in the same cycle, quiet while reset is asserted.
`define TARA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent.
`define TARA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/tara_pkg.sv
// Shared constants and types of the tie-averaged rank assigner.
package tara_pkg;

    // Longest array taken; items beyond it are dropped.
    localparam int MaxLen = 64;

    // Field widths of the item and the result.
    localparam int ValueW = 64;
    localparam int IndexW = 6;
    localparam int RankW  = 8;

    // Position counters must hold MaxLen itself.
    localparam int PosW  = $clog2(MaxLen + 1);
    localparam int AddrW = (MaxLen > 1) ? $clog2(MaxLen) : 1;

    // Rank sum is wide enough for 2 * start + count + 1 before truncation.
    localparam int SumW = (PosW + 2 > RankW) ? PosW + 2 : RankW;

    // Depth of the command queue between front and back.
    localparam int FifoDepth = 2;
    localparam int FifoAw    = $clog2(FifoDepth);

    // One run to flush: its first position, its length and the step flags.
    typedef struct packed {
        logic [PosW-1:0] start;
        logic [PosW-1:0] count;
        logic            run_last;
        logic            done;
        logic            ovf;
    } cmd_t;

    // Write port of the index buffer.
    typedef struct packed {
        logic              en;
        logic [AddrW-1:0]  addr;
        logic [IndexW-1:0] data;
    } wr_t;

endpackage

>>> design/tara_front.sv
// Front end: accepts sorted items, tracks runs and queues flush commands.
module tara_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [tara_pkg::ValueW-1:0] value_bits,
    input  logic [tara_pkg::IndexW-1:0] orig_index,
    input  logic                        last_item,
    input  logic                        done_taken,
    output logic                        push_valid,
    output tara_pkg::cmd_t              push_cmd,
    input  logic                        fifo_full,
    output tara_pkg::wr_t               wr
);
    import tara_pkg::*;

    // IEEE equality on bit patterns: NaN never matches, both zeros match.
    function automatic logic values_equal(input logic [ValueW-1:0] a,
                                          input logic [ValueW-1:0] b);
        logic [ValueW-2:0] mag_a;
        logic [ValueW-2:0] mag_b;
        logic [ValueW-2:0] inf;
        logic              result;
        mag_a = a[ValueW-2:0];
        mag_b = b[ValueW-2:0];
        inf   = {11'h7FF, 52'h0};
        if (mag_a > inf || mag_b > inf)
        begin
            result = 1'b0;
        end
        else if (mag_a == '0 && mag_b == '0)
        begin
            result = 1'b1;
        end
        else
        begin
            result = (a == b);
        end
        return result;
    endfunction

    logic [PosW-1:0]   start_reg, start_next;
    logic [PosW-1:0]   count_reg, count_next;
    logic [PosW-1:0]   pos_reg, pos_next;
    logic              have_prev_reg, have_prev_next;
    logic              ovf_reg, ovf_next;
    logic              last_pending_reg, last_pending_next;
    logic              cmd_a_v_reg, cmd_a_v_next;
    logic              cmd_b_v_reg, cmd_b_v_next;
    logic [ValueW-1:0] prev_value_reg;
    cmd_t              cmd_a_reg;
    cmd_t              cmd_b_reg;

    logic              accept;
    logic              in_range;
    logic              flush_a;
    logic              ovf_step;
    logic [PosW-1:0]   cnt_mid;
    logic [PosW-1:0]   start_mid;
    cmd_t              cmd_a_d;
    cmd_t              cmd_b_d;

    // One item at a time; stalls until its commands queue and a last array drains.
    assign in_stall = cmd_a_v_reg | cmd_b_v_reg | last_pending_reg;
    assign accept   = in_valid & ~in_stall;

    // Classify the item against the open run.
    always_comb
    begin
        in_range  = (pos_reg < PosW'(MaxLen));
        flush_a   = in_range & have_prev_reg & (count_reg != '0)
                    & ~values_equal(prev_value_reg, value_bits);
        ovf_step  = ovf_reg | ~in_range;
        cnt_mid   = flush_a ? '0 : count_reg;
        start_mid = (cnt_mid == '0) ? pos_reg : start_reg;

        cmd_a_d.start    = start_reg;
        cmd_a_d.count    = count_reg;
        cmd_a_d.run_last = ~last_item;
        cmd_a_d.done     = 1'b0;
        cmd_a_d.ovf      = ovf_step;

        cmd_b_d.start    = in_range ? start_mid : start_reg;
        cmd_b_d.count    = in_range ? cnt_mid + PosW'(1) : count_reg;
        cmd_b_d.run_last = 1'b1;
        cmd_b_d.done     = 1'b1;
        cmd_b_d.ovf      = ovf_step;

        wr.en   = accept & in_range;
        wr.addr = pos_reg[AddrW-1:0];
        wr.data = orig_index;
    end

    // Hand the held commands to the queue, the value-change flush first.
    assign push_valid = cmd_a_v_reg | cmd_b_v_reg;
    assign push_cmd   = cmd_a_v_reg ? cmd_a_reg : cmd_b_reg;

    // Next state of the run tracker.
    always_comb
    begin
        start_next        = start_reg;
        count_next        = count_reg;
        pos_next          = pos_reg;
        have_prev_next    = have_prev_reg;
        ovf_next          = ovf_reg;
        last_pending_next = last_pending_reg;
        cmd_a_v_next      = cmd_a_v_reg;
        cmd_b_v_next      = cmd_b_v_reg;

        if (push_valid && !fifo_full)
        begin
            if (cmd_a_v_reg)
            begin
                cmd_a_v_next = 1'b0;
            end
            else
            begin
                cmd_b_v_next = 1'b0;
            end
        end

        if (done_taken)
        begin
            last_pending_next = 1'b0;
        end

        if (accept)
        begin
            cmd_a_v_next = flush_a;
            cmd_b_v_next = last_item;
            if (last_item)
            begin
                // The array ends here: start the next one from scratch.
                start_next        = '0;
                count_next        = '0;
                pos_next          = '0;
                have_prev_next    = 1'b0;
                ovf_next          = 1'b0;
                last_pending_next = 1'b1;
            end
            else
            begin
                ovf_next = ovf_step;
                if (in_range)
                begin
                    start_next     = start_mid;
                    count_next     = cnt_mid + PosW'(1);
                    pos_next       = pos_reg + PosW'(1);
                    have_prev_next = 1'b1;
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg        <= '0;
            count_reg        <= '0;
            pos_reg          <= '0;
            have_prev_reg    <= 1'b0;
            ovf_reg          <= 1'b0;
            last_pending_reg <= 1'b0;
            cmd_a_v_reg      <= 1'b0;
            cmd_b_v_reg      <= 1'b0;
        end
        else
        begin
            start_reg        <= start_next;
            count_reg        <= count_next;
            pos_reg          <= pos_next;
            have_prev_reg    <= have_prev_next;
            ovf_reg          <= ovf_next;
            last_pending_reg <= last_pending_next;
            cmd_a_v_reg      <= cmd_a_v_next;
            cmd_b_v_reg      <= cmd_b_v_next;
        end
    end

    // Payload registers, loaded with each accepted item.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_a_reg <= cmd_a_d;
            cmd_b_reg <= cmd_b_d;
            if (in_range)
            begin
                prev_value_reg <= value_bits;
            end
        end
    end

endmodule

>>> design/tara_cmd_fifo.sv
// Short command queue that decouples the front end from the back end.
module tara_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    input  tara_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output tara_pkg::cmd_t pop_cmd,
    output logic           empty
);
    import tara_pkg::*;

    cmd_t              q_reg [FifoDepth];
    logic [FifoAw-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FifoAw-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FifoAw:0]   fill_reg, fill_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (fill_reg == (FifoAw + 1)'(FifoDepth));
    assign empty   = (fill_reg == '0);
    assign do_push = push_valid & ~full;
    assign do_pop  = pop & ~empty;
    assign pop_cmd = q_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == FifoAw'(FifoDepth - 1)) ? '0
                                                                 : wr_ptr_reg + FifoAw'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FifoAw'(FifoDepth - 1)) ? '0
                                                                 : rd_ptr_reg + FifoAw'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + (FifoAw + 1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - (FifoAw + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> design/tara_back.sv
// Back end: holds the index buffer and plays each queued run out as results.
module tara_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tara_pkg::wr_t               wr,
    input  logic                        fifo_empty,
    output logic                        pop,
    input  tara_pkg::cmd_t              pop_cmd,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [tara_pkg::IndexW-1:0] out_index,
    output logic [tara_pkg::RankW-1:0]  rank_twice,
    output logic                        run_last,
    output logic                        array_done,
    output logic                        overflow
);
    import tara_pkg::*;

    logic [IndexW-1:0] idx_mem [MaxLen];

    logic              cur_v_reg, cur_v_next;
    logic              out_valid_reg, out_valid_next;
    logic [AddrW-1:0]  cur_addr_reg;
    logic [PosW-1:0]   cur_rem_reg;
    logic [RankW-1:0]  cur_rank_reg;
    logic              cur_rl_reg;
    logic              cur_done_reg;
    logic              cur_ovf_reg;
    logic [IndexW-1:0] out_index_reg;
    logic [RankW-1:0]  rank_reg;
    logic              run_last_reg;
    logic              array_done_reg;
    logic              overflow_reg;

    logic              advance;
    logic              final_one;
    logic [SumW-1:0]   rank_sum;

    // Take a new run when idle; emit one result whenever the output slot frees up.
    always_comb
    begin
        pop       = ~cur_v_reg & ~fifo_empty;
        advance   = cur_v_reg & (~out_valid_reg | ~out_stall);
        final_one = (cur_rem_reg == PosW'(1));
        rank_sum  = (SumW'(pop_cmd.start) << 1) + SumW'(pop_cmd.count) + SumW'(1);

        cur_v_next     = cur_v_reg;
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            cur_v_next = 1'b1;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
            if (final_one)
            begin
                cur_v_next = 1'b0;
            end
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_v_reg     <= cur_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Index buffer; its registered read doubles as the output register.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            idx_mem[wr.addr] <= wr.data;
        end
        if (advance)
        begin
            out_index_reg <= idx_mem[cur_addr_reg];
        end
    end

    // Run walker and the result fields that travel with each read.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_addr_reg <= pop_cmd.start[AddrW-1:0];
            cur_rem_reg  <= pop_cmd.count;
            cur_rank_reg <= rank_sum[RankW-1:0];
            cur_rl_reg   <= pop_cmd.run_last;
            cur_done_reg <= pop_cmd.done;
            cur_ovf_reg  <= pop_cmd.ovf;
        end
        else if (advance)
        begin
            cur_addr_reg <= cur_addr_reg + AddrW'(1);
            cur_rem_reg  <= cur_rem_reg - PosW'(1);
        end
        if (advance)
        begin
            rank_reg       <= cur_rank_reg;
            run_last_reg   <= cur_rl_reg & final_one;
            array_done_reg <= cur_done_reg & final_one;
            overflow_reg   <= cur_ovf_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_index  = out_index_reg;
    assign rank_twice = rank_reg;
    assign run_last   = run_last_reg;
    assign array_done = array_done_reg;
    assign overflow   = overflow_reg;

endmodule

>>> design/tie_averaged_rank_assigner_top.sv
// Top level of the tie-averaged rank assigner.
//
//   Channel   Handshake            Fields
//   input     in_valid / in_stall  value_bits, orig_index, last_item
//   output    out_valid/out_stall  out_index, rank_twice, run_last, array_done, overflow
//
// An item is taken while in_stall is low; its flush commands enter the queue while the queue
// has room, and the input stalls until they are queued.
// The back end emits one result per cycle from the registered index buffer read while the
// output is not stalled.
// After an item marked last, input stalls until that array's final result is taken.
// Reset is asynchronous; the index buffer is not cleared and needs no clearing pass.
// Output stall holds the output register; the front keeps taking items until a flush
// command finds the queue full.
module tie_averaged_rank_assigner_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [tara_pkg::ValueW-1:0] value_bits,
    input  logic [tara_pkg::IndexW-1:0] orig_index,
    input  logic                        last_item,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [tara_pkg::IndexW-1:0] out_index,
    output logic [tara_pkg::RankW-1:0]  rank_twice,
    output logic                        run_last,
    output logic                        array_done,
    output logic                        overflow
);
    import tara_pkg::*;

    logic  push_valid;
    cmd_t  push_cmd;
    logic  fifo_full;
    logic  fifo_empty;
    logic  pop;
    cmd_t  pop_cmd;
    wr_t   wr;
    logic  done_taken;

    // Final result of an array taken downstream releases the front end.
    assign done_taken = out_valid & ~out_stall & array_done;

    tara_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value_bits (value_bits),
        .orig_index (orig_index),
        .last_item  (last_item),
        .done_taken (done_taken),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .fifo_full  (fifo_full),
        .wr         (wr)
    );

    tara_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .full       (fifo_full),
        .pop        (pop),
        .pop_cmd    (pop_cmd),
        .empty      (fifo_empty)
    );

    tara_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .fifo_empty (fifo_empty),
        .pop        (pop),
        .pop_cmd    (pop_cmd),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_index  (out_index),
        .rank_twice (rank_twice),
        .run_last   (run_last),
        .array_done (array_done),
        .overflow   (overflow)
    );

endmodule

>>> design/tara_checker.sv
// Port-level checks of the rank assigner and their binding to the top level.
`include "tie_averaged_rank_assigner_top_macros.svh"

module tara_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        last_item,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [tara_pkg::IndexW-1:0] out_index,
    input logic [tara_pkg::RankW-1:0]  rank_twice,
    input logic                        run_last,
    input logic                        array_done
);
    import tara_pkg::*;

    // A stalled result keeps its index and rank.
    `TARA_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(out_index) && $stable(rank_twice), "stalled result changed")

    // The final result of an array always closes its step.
    `TARA_ASSERT_NOW(a_done_closes, out_valid && array_done, run_last,
        "array_done without run_last")

    // Twice a one-based rank lies between 2 and twice the longest array.
    `TARA_ASSERT_NOW(a_rank_range, out_valid,
        rank_twice >= 8'd2 && rank_twice <= 8'd128, "rank out of range")

    // Input waits for the array to drain once its last item is in.
    `TARA_ASSERT_NEXT(a_last_stalls, in_valid && !in_stall && last_item, in_stall,
        "item taken behind a last item")

endmodule

bind tie_averaged_rank_assigner_top tara_checker u_tara_checker (.*);

>>> tb/tie_averaged_rank_assigner_top_tb.sv
// Self-checking testbench of the tie-averaged rank assigner.
`timescale 1ns / 100ps

module tie_averaged_rank_assigner_top_tb;

    import tara_pkg::*;

    // Cycles with no item accepted on either side before the run is abandoned.
    localparam int WatchdogLimit = 4000;
    // Cycles allowed after the last expected result for stray output.
    localparam int DrainCycles = 20;

    localparam logic [ValueW-1:0] DblZeroPos = 64'h0000_0000_0000_0000;
    localparam logic [ValueW-1:0] DblZeroNeg = 64'h8000_0000_0000_0000;
    localparam logic [ValueW-1:0] DblOne     = 64'h3FF0_0000_0000_0000;
    localparam logic [ValueW-1:0] DblTwo     = 64'h4000_0000_0000_0000;
    localparam logic [ValueW-1:0] DblThree   = 64'h4008_0000_0000_0000;
    localparam logic [ValueW-1:0] DblMinusOne = 64'hBFF0_0000_0000_0000;
    localparam logic [ValueW-1:0] DblInfPos  = 64'h7FF0_0000_0000_0000;
    localparam logic [ValueW-1:0] DblInfNeg  = 64'hFFF0_0000_0000_0000;
    localparam logic [ValueW-1:0] DblNanQuiet = 64'h7FF8_0000_0000_0000;
    localparam logic [ValueW-1:0] DblNanLow  = 64'h7FF0_0000_0000_0001;
    localparam logic [ValueW-1:0] DblAllOnes = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [ValueW-1:0] MagMask    = 64'h7FFF_FFFF_FFFF_FFFF;

    // One expected rank result.
    typedef struct {
        logic [IndexW-1:0] index;
        logic [RankW-1:0]  rank;
        logic              run_last;
        logic              done;
        logic              ovf;
    } rank_result_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [ValueW-1:0] value_bits;
    logic [IndexW-1:0] orig_index;
    logic              last_item;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [IndexW-1:0] out_index;
    logic [RankW-1:0]  rank_twice;
    logic              run_last;
    logic              array_done;
    logic              overflow;

    // Shadow state of the rank predictor.
    logic [IndexW-1:0] run_idx [MaxLen];
    int                run_start;
    int                run_len;
    int                pos_count;
    logic [ValueW-1:0] prev_value;
    logic              have_prev;
    logic              drop_seen;

    rank_result_t      step_ranks[$];
    rank_result_t      pending_ranks[$];
    int                mismatch_count = 0;
    int                idle_cycles = 0;
    int                stall_left = 0;
    logic              idling_on = 1'b1;

    tie_averaged_rank_assigner_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value_bits (value_bits),
        .orig_index (orig_index),
        .last_item  (last_item),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_index  (out_index),
        .rank_twice (rank_twice),
        .run_last   (run_last),
        .array_done (array_done),
        .overflow   (overflow)
    );

    // Clock with a 2 ns period.
    always #1 clk = ~clk;

    // IEEE equality on raw bit patterns: NaN never matches, the two zeros do.
    function automatic logic doubles_equal(input logic [ValueW-1:0] a,
                                           input logic [ValueW-1:0] b);
        if ((a & MagMask) > DblInfPos || (b & MagMask) > DblInfPos)
            return 1'b0;
        if ((a & MagMask) == 0 && (b & MagMask) == 0)
            return 1'b1;
        return a == b;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Random value biased towards ties, signed zeros, infinities and NaNs.
    function automatic logic [ValueW-1:0] pick_value(input logic [ValueW-1:0] last_v);
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return last_v;
        if (r < 50)
            return {$urandom_range(0, 1) == 1, 63'b0};
        if (r < 55)
            return {$urandom_range(0, 1) == 1, 11'h7FF, 51'($urandom) | 52'h1};
        if (r < 60)
            return {$urandom_range(0, 1) == 1, 11'h7FF, 52'b0};
        return {$urandom, $urandom};
    endfunction

    // Emit every buffered index of the current run with its averaged rank.
    task automatic flush_run();
        rank_result_t r;
        logic [RankW-1:0] twice;
        twice = RankW'(2 * run_start + run_len + 1);
        for (int k = 0; k < run_len; k++)
        begin
            r.index    = run_idx[k];
            r.rank     = twice;
            r.run_last = 1'b0;
            r.done     = 1'b0;
            r.ovf      = 1'b0;
            step_ranks.push_back(r);
        end
        run_len = 0;
    endtask

    // Work out the results that one accepted item causes and queue them.
    task automatic predict_ranks(input logic [ValueW-1:0] v, input logic [IndexW-1:0] idx,
                                 input logic last);
        int n;
        step_ranks.delete();
        if (pos_count < MaxLen)
        begin
            if (have_prev && run_len > 0 && !doubles_equal(prev_value, v))
                flush_run();
            if (run_len == 0)
                run_start = pos_count;
            if (run_len < MaxLen)
            begin
                run_idx[run_len] = idx;
                run_len++;
            end
            pos_count++;
            prev_value = v;
            have_prev  = 1'b1;
        end
        else
            drop_seen = 1'b1;

        if (last)
            flush_run();

        n = step_ranks.size();
        for (int k = 0; k < n; k++)
        begin
            step_ranks[k].run_last = (k == n - 1);
            step_ranks[k].done     = last && (k == n - 1);
            step_ranks[k].ovf      = drop_seen;
            pending_ranks.push_back(step_ranks[k]);
        end

        if (last)
        begin
            run_start  = 0;
            run_len    = 0;
            pos_count  = 0;
            prev_value = '0;
            have_prev  = 1'b0;
            drop_seen  = 1'b0;
        end
    endtask

    // Offer one item after an optional gap and wait until it is taken.
    task automatic send_item(input logic [ValueW-1:0] v, input logic [IndexW-1:0] idx,
                             input logic last);
        int gap;
        gap = idling_on ? pick_gap() : 0;
        repeat (gap)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid   = 1'b1;
        value_bits = v;
        orig_index = idx;
        last_item  = last;
        do
            @(posedge clk);
        while (in_stall);
        predict_ranks(v, idx, last);
    endtask

    // Single items, runs of ties and a last item that ends a run.
    task automatic test_basic_runs();
        send_item(DblOne, 6'd5, 1'b1);
        send_item(DblMinusOne, 6'd0, 1'b0);
        send_item(DblOne, 6'd63, 1'b0);
        send_item(DblOne, 6'd1, 1'b0);
        send_item(DblOne, 6'd2, 1'b0);
        send_item(DblTwo, 6'd3, 1'b1);
        send_item(DblThree, 6'd20, 1'b0);
        send_item(DblThree, 6'd21, 1'b1);
    endtask

    // Signed zeros tie; NaNs never tie, even with identical bits; infinities do.
    task automatic test_zero_inf_nan();
        send_item(DblInfNeg, 6'd9, 1'b0);
        send_item(DblZeroNeg, 6'd10, 1'b0);
        send_item(DblZeroPos, 6'd11, 1'b0);
        send_item(DblNanQuiet, 6'd12, 1'b0);
        send_item(DblNanQuiet, 6'd13, 1'b0);
        send_item(DblNanLow, 6'd14, 1'b0);
        send_item(DblInfPos, 6'd15, 1'b0);
        send_item(DblInfPos, 6'd16, 1'b0);
        send_item(DblAllOnes, 6'd17, 1'b0);
        send_item(DblAllOnes, 6'd18, 1'b1);
    endtask

    // A full-length array: 63 ties flushed by a different last item, top rank reached.
    task automatic test_full_length_array();
        for (int i = 0; i < MaxLen - 1; i++)
            send_item(DblTwo, IndexW'(i), 1'b0);
        send_item(DblThree, IndexW'(MaxLen - 1), 1'b1);
    endtask

    // Items beyond the maximum length are dropped; a dropped last item still flushes.
    task automatic test_overflow_drop();
        logic [ValueW-1:0] v;
        v = DblOne;
        for (int i = 0; i < MaxLen; i++)
        begin
            v = pick_value(v);
            send_item(v, IndexW'($urandom_range(0, 63)), 1'b0);
        end
        for (int i = 0; i < 3; i++)
            send_item({$urandom, $urandom}, IndexW'($urandom_range(0, 63)), i == 2);
    endtask

    // Random arrays, mostly short, with ties and special values; idling varies per array.
    task automatic test_random_arrays(input int item_budget);
        logic [ValueW-1:0] v;
        int len;
        while (item_budget > 0)
        begin
            len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 24);
            idling_on = ($urandom_range(0, 3) != 0);
            v = {$urandom, $urandom};
            for (int i = 0; i < len; i++)
            begin
                v = pick_value(v);
                send_item(v, IndexW'($urandom_range(0, 63)), i == len - 1);
                item_budget--;
            end
        end
        idling_on = 1'b1;
    endtask

    // Output stall in bursts, mostly short, some long; none begins while idling is off.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (idling_on && $urandom_range(0, 99) < 25)
        begin
            out_stall  <= 1'b1;
            stall_left <= pick_gap();
        end
        else
            out_stall <= 1'b0;
    end

    // Compare each result taken with the oldest expected one.
    always @(posedge clk)
    begin
        rank_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_ranks.size() == 0)
            begin
                $display("%0t: unexpected result index %0d rank %0d", $time, out_index,
                         rank_twice);
                mismatch_count++;
            end
            else
            begin
                exp_r = pending_ranks.pop_front();
                if (out_index !== exp_r.index)
                begin
                    $display("%0t: out_index expected %0d got %0d", $time, exp_r.index,
                             out_index);
                    mismatch_count++;
                end
                if (rank_twice !== exp_r.rank)
                begin
                    $display("%0t: rank_twice expected %0d got %0d", $time, exp_r.rank,
                             rank_twice);
                    mismatch_count++;
                end
                if (run_last !== exp_r.run_last)
                begin
                    $display("%0t: run_last expected %0b got %0b", $time, exp_r.run_last,
                             run_last);
                    mismatch_count++;
                end
                if (array_done !== exp_r.done)
                begin
                    $display("%0t: array_done expected %0b got %0b", $time, exp_r.done,
                             array_done);
                    mismatch_count++;
                end
                if (overflow !== exp_r.ovf)
                begin
                    $display("%0t: overflow expected %0b got %0b", $time, exp_r.ovf,
                             overflow);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither side moves an item.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WatchdogLimit)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Reset, the test sequence and the final verdict.
    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        value_bits = '0;
        orig_index = '0;
        last_item  = 1'b0;
        run_start  = 0;
        run_len    = 0;
        pos_count  = 0;
        prev_value = '0;
        have_prev  = 1'b0;
        drop_seen  = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_basic_runs();
        test_zero_inf_nan();
        test_full_length_array();
        test_overflow_drop();
        test_random_arrays(130);

        @(negedge clk);
        in_valid = 1'b0;
        while (pending_ranks.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/tara_pkg.sv
design/tara_front.sv
design/tara_cmd_fifo.sv
design/tara_back.sv
design/tie_averaged_rank_assigner_top.sv
design/tara_checker.sv
tb/tie_averaged_rank_assigner_top_tb.sv
